>>> hw/rtl/port_range_block_allocator_unit_macros.svh
// Assertion macros for the port range block allocator checker.
// Needs clk and arst_n in scope where a macro is used.
`ifndef PORT_RANGE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define PORT_RANGE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ant
`define PRBA_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ant
`define PRBA_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/prba_pkg.sv
// Shared types, constants and the microprogram of the port range block allocator.
// No dependencies; used by the sequencer, the datapath and the top level.
package prba_pkg;

	localparam int PORT_BITS_DEF = 16;
	localparam int IO_W          = 16;
	localparam int HI_W          = 17;
	localparam int MAX_ENTRIES   = 17;
	localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

	// Microprogram step addresses
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_CHECK  = 3'd1,
		ST_SHRINK = 3'd2,
		ST_DOWN   = 3'd3,
		ST_UP     = 3'd4,
		ST_FIN    = 3'd5
	} step_t;

	// Branch conditions
	typedef enum logic [2:0] {
		C_ALWAYS = 3'd0,
		C_IN     = 3'd1,
		C_EMPTY  = 3'd2,
		C_FIT    = 3'd3,
		C_DOWN   = 3'd4,
		C_UP     = 3'd5,
		C_MORE   = 3'd6
	} cond_t;

	// Datapath operations
	typedef enum logic [3:0] {
		ACT_NONE   = 4'd0,
		ACT_LOAD   = 4'd1,
		ACT_EMPTY  = 4'd2,
		ACT_SHRINK = 4'd3,
		ACT_FIRST  = 4'd4,
		ACT_DOWN   = 4'd5,
		ACT_UP     = 4'd6,
		ACT_HALVE  = 4'd7,
		ACT_FINISH = 4'd8
	} act_t;

	// One control word: first test wins, else second test, else fall-through
	typedef struct packed {
		cond_t cond_a;
		act_t  act_a;
		step_t next_a;
		cond_t cond_b;
		act_t  act_b;
		step_t next_b;
		act_t  act_c;
		step_t next_c;
	} uword_t;

	// Flags from the datapath to the sequencer
	typedef struct packed {
		logic empty;
		logic fit;
		logic down_ok;
		logic up_ok;
		logic more;
		logic out_busy;
	} dp_stat_t;

	// Control store
	function automatic uword_t prba_urom(input step_t st);
		uword_t w;
		w = '{cond_a: C_ALWAYS, act_a: ACT_NONE, next_a: ST_IDLE,
		      cond_b: C_ALWAYS, act_b: ACT_NONE, next_b: ST_IDLE,
		      act_c: ACT_NONE, next_c: ST_IDLE};
		unique case (st)
			ST_IDLE: begin
				w.cond_a = C_IN;     w.act_a = ACT_LOAD;   w.next_a = ST_CHECK;
				w.cond_b = C_ALWAYS; w.act_b = ACT_NONE;   w.next_b = ST_IDLE;
			end
			ST_CHECK: begin
				w.cond_a = C_EMPTY;  w.act_a = ACT_EMPTY;  w.next_a = ST_IDLE;
				w.cond_b = C_ALWAYS; w.act_b = ACT_NONE;   w.next_b = ST_SHRINK;
			end
			ST_SHRINK: begin
				w.cond_a = C_FIT;    w.act_a = ACT_FIRST;  w.next_a = ST_DOWN;
				w.cond_b = C_ALWAYS; w.act_b = ACT_SHRINK; w.next_b = ST_SHRINK;
			end
			ST_DOWN: begin
				w.cond_a = C_DOWN;   w.act_a = ACT_DOWN;   w.next_a = ST_DOWN;
				w.cond_b = C_ALWAYS; w.act_b = ACT_NONE;   w.next_b = ST_UP;
			end
			ST_UP: begin
				w.cond_a = C_UP;     w.act_a = ACT_UP;     w.next_a = ST_UP;
				w.cond_b = C_MORE;   w.act_b = ACT_HALVE;  w.next_b = ST_DOWN;
				w.act_c  = ACT_HALVE; w.next_c = ST_FIN;
			end
			ST_FIN: begin
				w.cond_a = C_ALWAYS; w.act_a = ACT_FINISH; w.next_a = ST_IDLE;
			end
			default: begin
				w.cond_a = C_ALWAYS; w.act_a = ACT_NONE;   w.next_a = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/port_range_block_allocator_unit.sv
// Port range block allocator, top level; uses prba_pkg, prba_useq and prba_dpath. Each request
// (range_start, range_end inclusive, port_count) is covered by aligned power-of-two blocks:
// the largest block that fits is placed first, then the run grows down and up with halving
// sizes until the count is met, the sizes run out or 17 entries are out. One output word per
// block, the final one with last_entry set and run_low, run_high and total_covered final; an
// empty range or a zero count gives a single word with found clear. A small microprogram
// steps a shared datapath one step per cycle while the output register can take its words; a
// request runs through k halvings of the first block from half the port space, L growth levels
// (one per halving of the block size, at most log2 of the first block plus one) and N entries,
// and a step that must load a full output register waits for out_ready. One request is
// worked at a time; the next is taken once the last word is in the output register.
module port_range_block_allocator_unit #(
	parameter int PORT_BITS = prba_pkg::PORT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [prba_pkg::IO_W-1:0]  range_start,
	input  logic [prba_pkg::IO_W-1:0]  range_end,
	input  logic [prba_pkg::IO_W-1:0]  port_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [prba_pkg::IO_W-1:0]  block_base,
	output logic [prba_pkg::IO_W-1:0]  block_size,
	output logic [prba_pkg::IO_W-1:0]  run_low,
	output logic [prba_pkg::HI_W-1:0]  run_high,
	output logic [prba_pkg::IO_W-1:0]  total_covered,
	output logic                       found,
	output logic                       last_entry
);
	import prba_pkg::*;

	dp_stat_t stat;
	act_t     act;

	// Sequence the microprogram
	prba_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.act      (act)
	);

	// Run the datapath and hold the output word
	prba_dpath #(
		.PORT_BITS (PORT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.act           (act),
		.range_start   (range_start),
		.range_end     (range_end),
		.port_count    (port_count),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.block_base    (block_base),
		.block_size    (block_size),
		.run_low       (run_low),
		.run_high      (run_high),
		.total_covered (total_covered),
		.found         (found),
		.last_entry    (last_entry),
		.stat          (stat)
	);

endmodule

>>> hw/rtl/prba_useq.sv
// Microprogram sequencer: step counter, control store lookup and branch select.
// Depends on prba_pkg.
module prba_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prba_pkg::dp_stat_t stat,
	output prba_pkg::act_t     act
);
	import prba_pkg::*;

	step_t  upc_q;
	uword_t uw;
	logic   in_acc;
	logic   hit_a;
	logic   hit_b;
	logic   needs_out;
	logic   stall;
	act_t   act_sel;
	step_t  next_sel;

	function automatic logic test(input cond_t c, input dp_stat_t s, input logic acc);
		logic r;
		unique case (c)
			C_ALWAYS: r = 1'b1;
			C_IN:     r = acc;
			C_EMPTY:  r = s.empty;
			C_FIT:    r = s.fit;
			C_DOWN:   r = s.down_ok;
			C_UP:     r = s.up_ok;
			C_MORE:   r = s.more;
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	// Fetch the control word and pick the branch
	always_comb begin
		uw       = prba_urom(upc_q);
		in_ready = (upc_q == ST_IDLE);
		in_acc   = in_valid && in_ready;
		hit_a    = test(uw.cond_a, stat, in_acc);
		hit_b    = test(uw.cond_b, stat, in_acc);
		if (hit_a) begin
			act_sel  = uw.act_a;
			next_sel = uw.next_a;
		end else if (hit_b) begin
			act_sel  = uw.act_b;
			next_sel = uw.next_b;
		end else begin
			act_sel  = uw.act_c;
			next_sel = uw.next_c;
		end
	end

	// Hold the step while a word must go out and the output register is full
	always_comb begin
		unique case (act_sel) inside
			ACT_EMPTY, ACT_DOWN, ACT_UP, ACT_FINISH: needs_out = 1'b1;
			default:                                 needs_out = 1'b0;
		endcase
		stall = needs_out && stat.out_busy;
		act   = stall ? ACT_NONE : act_sel;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else if (!stall) begin
			upc_q <= next_sel;
		end
	end

endmodule

>>> hw/rtl/prba_dpath.sv
// Datapath: request registers, run bounds, pending entry and output word register.
// Depends on prba_pkg; driven by operation codes from prba_useq.
module prba_dpath #(
	parameter int PORT_BITS = prba_pkg::PORT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prba_pkg::act_t             act,
	input  logic [prba_pkg::IO_W-1:0]  range_start,
	input  logic [prba_pkg::IO_W-1:0]  range_end,
	input  logic [prba_pkg::IO_W-1:0]  port_count,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [prba_pkg::IO_W-1:0]  block_base,
	output logic [prba_pkg::IO_W-1:0]  block_size,
	output logic [prba_pkg::IO_W-1:0]  run_low,
	output logic [prba_pkg::HI_W-1:0]  run_high,
	output logic [prba_pkg::IO_W-1:0]  total_covered,
	output logic                       found,
	output logic                       last_entry,
	output prba_pkg::dp_stat_t         stat
);
	import prba_pkg::*;

	localparam int AW = (PORT_BITS < IO_W) ? PORT_BITS : IO_W;
	localparam int XW = AW + 1;
	localparam logic [AW-1:0] B_CAP = {1'b1, {(AW-1){1'b0}}};

	// Request and run registers
	logic [AW-1:0]    s_q, e_q, c_q, b_q, blk_q, lo_q, total_q;
	logic [XW-1:0]    hi_q;
	logic [CNT_W-1:0] n_q;

	// Pending entry, sent once the next step shows whether it is the last
	logic [AW-1:0]    pbase_q, psize_q, plo_q, ptotal_q;
	logic [XW-1:0]    phi_q;

	// Output word register
	logic [IO_W-1:0]  obase_q, osize_q, olo_q, ototal_q;
	logic [HI_W-1:0]  ohi_q;
	logic             ofound_q, olast_q, ovalid_q;

	logic [XW-1:0]    b_x, b_m1, base_x, end_x;
	logic [XW-1:0]    blk_x, blk_m1, sum_x, lo_dn, up_end, hi_up;
	logic             n_lt, room, push;

	// Placement of the first block and the growth tests
	always_comb begin
		b_x    = {1'b0, b_q};
		b_m1   = b_x - XW'(1);
		base_x = ({1'b0, s_q} + b_m1) & ~b_m1;
		end_x  = base_x + b_m1;
		blk_x  = {1'b0, blk_q};
		blk_m1 = blk_x - XW'(1);
		sum_x  = {1'b0, total_q} + blk_x;
		lo_dn  = {1'b0, lo_q} - blk_x;
		up_end = hi_q + blk_m1;
		hi_up  = hi_q + blk_x;
		n_lt   = (n_q < CNT_W'(MAX_ENTRIES));
		room   = (sum_x <= {1'b0, c_q});

		stat.empty    = (e_q < s_q) || (c_q == '0);
		stat.fit      = (b_q == AW'(1)) || ((b_q <= c_q) && (end_x <= {1'b0, e_q}));
		stat.down_ok  = n_lt && room && (lo_q >= blk_q) && (lo_dn[AW-1:0] >= s_q)
		                && ((lo_dn & blk_m1) == '0);
		stat.up_ok    = n_lt && room && (up_end <= {1'b0, e_q}) && ((hi_q & blk_m1) == '0);
		stat.more     = (total_q < c_q) && (blk_q[AW-1:1] != '0) && n_lt;
		stat.out_busy = ovalid_q && !out_ready;
	end

	// Decode which operations load the output register
	always_comb begin
		case (act) inside
			ACT_EMPTY, ACT_DOWN, ACT_UP, ACT_FINISH: push = 1'b1;
			default:                                 push = 1'b0;
		endcase
	end

	// Control: entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (act)
				ACT_FIRST:        n_q <= CNT_W'(1);
				ACT_DOWN, ACT_UP: n_q <= n_q + CNT_W'(1);
				default:          n_q <= n_q;
			endcase
			if (push) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload: carry out the operation of this step
	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				s_q <= range_start[AW-1:0];
				e_q <= range_end[AW-1:0];
				c_q <= port_count[AW-1:0];
				b_q <= B_CAP;
			end
			ACT_SHRINK: begin
				b_q <= b_q >> 1;
			end
			ACT_FIRST: begin
				lo_q     <= base_x[AW-1:0];
				hi_q     <= base_x + b_x;
				total_q  <= b_q;
				blk_q    <= b_q;
				pbase_q  <= base_x[AW-1:0];
				psize_q  <= b_q;
				plo_q    <= base_x[AW-1:0];
				phi_q    <= base_x + b_x;
				ptotal_q <= b_q;
			end
			ACT_DOWN: begin
				lo_q     <= lo_dn[AW-1:0];
				total_q  <= sum_x[AW-1:0];
				pbase_q  <= lo_dn[AW-1:0];
				psize_q  <= blk_q;
				plo_q    <= lo_dn[AW-1:0];
				phi_q    <= hi_q;
				ptotal_q <= sum_x[AW-1:0];
			end
			ACT_UP: begin
				hi_q     <= hi_up;
				total_q  <= sum_x[AW-1:0];
				pbase_q  <= hi_q[AW-1:0];
				psize_q  <= blk_q;
				plo_q    <= lo_q;
				phi_q    <= hi_up;
				ptotal_q <= sum_x[AW-1:0];
			end
			ACT_HALVE: begin
				blk_q <= blk_q >> 1;
			end
			default: begin
			end
		endcase

		// Load the output word: empty result, or the pending entry
		if (act == ACT_EMPTY) begin
			obase_q  <= '0;
			osize_q  <= '0;
			olo_q    <= '0;
			ohi_q    <= '0;
			ototal_q <= '0;
			ofound_q <= 1'b0;
			olast_q  <= 1'b1;
		end else if (push) begin
			obase_q  <= IO_W'(pbase_q);
			osize_q  <= IO_W'(psize_q);
			olo_q    <= IO_W'(plo_q);
			ohi_q    <= HI_W'(phi_q);
			ototal_q <= IO_W'(ptotal_q);
			ofound_q <= 1'b1;
			olast_q  <= (act == ACT_FINISH);
		end
	end

	assign out_valid     = ovalid_q;
	assign block_base    = obase_q;
	assign block_size    = osize_q;
	assign run_low       = olo_q;
	assign run_high      = ohi_q;
	assign total_covered = ototal_q;
	assign found         = ofound_q;
	assign last_entry    = olast_q;

endmodule

>>> hw/rtl/prba_checker.sv
// Port-level checks for the port range block allocator, bound to the top level.
// Depends on prba_pkg and port_range_block_allocator_unit_macros.svh.
`include "port_range_block_allocator_unit_macros.svh"

module prba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [prba_pkg::IO_W-1:0]  range_start,
	input logic [prba_pkg::IO_W-1:0]  range_end,
	input logic [prba_pkg::IO_W-1:0]  port_count,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [prba_pkg::IO_W-1:0]  block_base,
	input logic [prba_pkg::IO_W-1:0]  block_size,
	input logic [prba_pkg::IO_W-1:0]  run_low,
	input logic [prba_pkg::HI_W-1:0]  run_high,
	input logic [prba_pkg::IO_W-1:0]  total_covered,
	input logic                       found,
	input logic                       last_entry
);
	import prba_pkg::*;

	logic [HI_W-1:0] span_end;
	logic            aligned;
	logic            in_seen;

	// Run end implied by its low bound and the ports covered
	assign span_end = {1'b0, run_low} + {1'b0, total_covered};
	assign aligned  = ((block_base & (block_size - IO_W'(1))) == '0);
	assign in_seen  = in_valid && in_ready && (range_start == range_start)
	                  && (range_end == range_end) && (port_count == port_count);

	// An empty result is a single all-zero word
	`PRBA_ASSERT_NOW(a_empty_word, out_valid && !found,
		(block_size == '0) && (total_covered == '0) && last_entry, "empty result malformed")

	// The run is contiguous: its span equals the ports covered
	`PRBA_ASSERT_NOW(a_run_span, out_valid, run_high == span_end, "run span mismatch")

	// Every block is a power of two aligned to its size
	`PRBA_ASSERT_NOW(a_block_shape, out_valid && found,
		$onehot(block_size) && aligned, "block not aligned power of two")

	// A stalled output word holds
	`PRBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready && !in_seen,
		out_valid && $stable(block_base) && $stable(block_size) && $stable(last_entry),
		"output word changed while stalled")

endmodule

bind port_range_block_allocator_unit prba_checker u_prba_checker (.*);
